>>> rtl/assert_macros.svh
// Assertion macros shared by the key/value table RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define SKVT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the cycle after.
`define SKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/skvt_pkg.sv
// Package for the small key/value table: port widths, parameter defaults,
// operation codes, sequencer states and the memory control bundle.
// Depends on nothing; used by skvt_mem and small_key_value_table_unit.
package skvt_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned KEY_BITS_DEF   = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned OP_W         = 2;
  localparam int unsigned KEY_PORT_W   = 64;
  localparam int unsigned VALUE_PORT_W = 32;
  localparam int unsigned COUNT_PORT_W = 5;
  localparam int unsigned S_DATA_W     = 96;
  localparam int unsigned M_DATA_W     = 48;
  localparam int unsigned M_PAD_W      = M_DATA_W - (1 + VALUE_PORT_W + COUNT_PORT_W + 3);

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_UPDATE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_key;
    logic wr_val;
  } mem_ctrl_t;

endpackage

>>> rtl/skvt_mem.sv
// Entry memory of the key/value table: key and value arrays with one
// write port and one registered read port. Depends on skvt_pkg.
module skvt_mem import skvt_pkg::*; #(
  parameter int unsigned DEPTH      = CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  mem_ctrl_t             ctrl_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [AW-1:0]         raddr_i,
  input  logic [KEY_BITS-1:0]   wkey_i,
  input  logic [VALUE_BITS-1:0] wval_i,
  output logic [KEY_BITS-1:0]   rkey_o,
  output logic [VALUE_BITS-1:0] rval_o
);

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_key) begin
      key_mem[waddr_i] <= wkey_i;
    end
    if (ctrl_i.rd_en) begin
      rkey_o <= key_mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_val) begin
      val_mem[waddr_i] <= wval_i;
    end
    if (ctrl_i.rd_en) begin
      rval_o <= val_mem[raddr_i];
    end
  end

endmodule

>>> rtl/small_key_value_table_unit.sv
// Top level of the small key/value table: sequencer, shared key comparator
// and output register. Depends on skvt_pkg, skvt_mem and assert_macros.svh.
//
// Usage: one operation enters on the slave stream per transfer. tuser carries
// the operation (lookup, insert, delete, update-or-insert); tdata carries the
// key in bits 63:0 and the new value in bits 95:64. Each operation produces
// exactly one result transfer on the master stream, whose tdata carries, from
// bit 0 up: found, read_value (32), entry_count (5), is_empty, is_full,
// status, then zero padding to 48 bits.
// Operation: the table has a single read port and one key comparator, and a
// scan visits the entries in order from slot 0, each in a read state
// (S_SCAN_RD) and then a compare state (S_SCAN_CMP). A scan stops at the
// first match or after the last entry, so a miss visits every entry; an empty
// table is not scanned. A delete that hits then slides each later entry down
// one slot through S_SHIFT_RD and S_SHIFT_WR. The slave side is ready only
// while the sequencer is idle, so no new operation enters during a scan or slide.
// Reset clears the fill count, so the table starts empty; entry contents need
// no clearing. A result waits in the output register while the receiver
// stalls; the next operation is accepted meanwhile and its result is held
// back until the register is free.
`include "assert_macros.svh"

module small_key_value_table_unit import skvt_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,  // key [63:0], new_value [95:64]
  input  logic [OP_W-1:0]     s_axis_tuser_i,  // op [1:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o   // found, read_value, entry_count,
                                               // is_empty, is_full, status, pad
);

  // Address width of the entry memory and width of the fill count.
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_e state_q, state_d;

  op_e                   op_q, op_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [VALUE_BITS-1:0] old_q, old_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         slot_q, slot_d;
  logic                  hit_q, hit_d;
  logic                  status_q, status_d;

  logic                    m_valid_q, m_valid_d;
  logic                    out_found_q, out_found_d;
  logic [VALUE_PORT_W-1:0] out_value_q, out_value_d;
  logic [COUNT_PORT_W-1:0] out_count_q, out_count_d;
  logic                    out_empty_q, out_empty_d;
  logic                    out_full_q, out_full_d;
  logic                    out_status_q, out_status_d;

  mem_ctrl_t             mem_ctrl;
  logic [AW-1:0]         waddr;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wval;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;

  logic                           accept;
  logic                           out_free;
  logic [CW-1:0]                  idx_inc;
  logic [CW-1:0]                  idx_dec;
  logic [CW-1:0]                  slot_inc;
  logic                           key_match;
  logic                           is_full_now;
  logic [KEY_BITS-1:0]            key_in;
  logic [VALUE_BITS+VALUE_PORT_W-1:0] val_in_ext;
  logic [VALUE_BITS+VALUE_PORT_W-1:0] old_out_ext;
  logic [CW+COUNT_PORT_W-1:0]     count_out_ext;

  assign accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free    = !m_valid_q || m_axis_tready_i;
  assign idx_inc     = idx_q + 1'b1;
  assign idx_dec     = idx_q - 1'b1;
  assign slot_inc    = slot_q + 1'b1;
  assign key_match   = (rkey == key_q);
  assign is_full_now = (count_q == CAP_C);

  // Key bits above KEY_BITS are dropped; the value is resized to VALUE_BITS.
  assign key_in        = s_axis_tdata_i[KEY_BITS-1:0];
  assign val_in_ext    = {{VALUE_BITS{1'b0}}, s_axis_tdata_i[KEY_PORT_W +: VALUE_PORT_W]};
  assign old_out_ext   = {{VALUE_PORT_W{1'b0}}, old_q};
  assign count_out_ext = {{COUNT_PORT_W{1'b0}}, count_q};

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{M_PAD_W{1'b0}}, out_status_q, out_full_q, out_empty_q,
                            out_count_q, out_value_q, out_found_q};

  skvt_mem #(
    .DEPTH      (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .waddr_i (waddr),
    .raddr_i (idx_q[AW-1:0]),
    .wkey_i  (wkey),
    .wval_i  (wval),
    .rkey_o  (rkey),
    .rval_o  (rval)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = (count_q == '0) ? S_DECIDE : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (key_match || (idx_inc == count_q)) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        if ((op_q == OP_DELETE) && hit_q && (slot_inc != count_q)) begin
          state_d = S_SHIFT_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT_RD: begin
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        state_d = (idx_inc == count_q) ? S_DONE : S_SHIFT_RD;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath and memory control for each sequencer state.
  always_comb begin
    op_d     = op_q;
    key_d    = key_q;
    val_d    = val_q;
    old_d    = old_q;
    count_d  = count_q;
    idx_d    = idx_q;
    slot_d   = slot_q;
    hit_d    = hit_q;
    status_d = status_q;
    mem_ctrl = '0;
    waddr    = count_q[AW-1:0];
    wkey     = key_q;
    wval     = val_q;

    m_valid_d    = m_valid_q && !m_axis_tready_i;
    out_found_d  = out_found_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    out_full_d   = out_full_q;
    out_status_d = out_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = op_e'(s_axis_tuser_i);
          key_d    = key_in;
          val_d    = val_in_ext[VALUE_BITS-1:0];
          idx_d    = '0;
          hit_d    = 1'b0;
          status_d = 1'b0;
        end
      end
      S_SCAN_RD: begin
        mem_ctrl.rd_en = 1'b1;
      end
      S_SCAN_CMP: begin
        if (key_match) begin
          hit_d  = 1'b1;
          slot_d = idx_q;
          old_d  = rval;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_DECIDE: begin
        case (op_q)
          OP_LOOKUP: begin
            status_d = !hit_q;
          end
          OP_INSERT: begin
            if (hit_q || is_full_now) begin
              status_d = 1'b1;
            end else begin
              mem_ctrl.wr_key = 1'b1;
              mem_ctrl.wr_val = 1'b1;
              count_d         = count_q + 1'b1;
            end
          end
          OP_DELETE: begin
            if (!hit_q) begin
              status_d = 1'b1;
            end else begin
              idx_d = slot_inc;
              // Deleting the last entry needs no slide.
              if (slot_inc == count_q) begin
                count_d = count_q - 1'b1;
              end
            end
          end
          default: begin
            if (hit_q) begin
              mem_ctrl.wr_val = 1'b1;
              waddr           = slot_q[AW-1:0];
            end else if (is_full_now) begin
              status_d = 1'b1;
            end else begin
              mem_ctrl.wr_key = 1'b1;
              mem_ctrl.wr_val = 1'b1;
              count_d         = count_q + 1'b1;
            end
          end
        endcase
      end
      S_SHIFT_RD: begin
        mem_ctrl.rd_en = 1'b1;
      end
      S_SHIFT_WR: begin
        mem_ctrl.wr_key = 1'b1;
        mem_ctrl.wr_val = 1'b1;
        waddr           = idx_dec[AW-1:0];
        wkey            = rkey;
        wval            = rval;
        idx_d           = idx_inc;
        if (idx_inc == count_q) begin
          count_d = count_q - 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_valid_d    = 1'b1;
          out_found_d  = hit_q;
          out_value_d  = hit_q ? old_out_ext[VALUE_PORT_W-1:0] : '0;
          out_count_d  = count_out_ext[COUNT_PORT_W-1:0];
          out_empty_d  = (count_q == '0);
          out_full_d   = is_full_now;
          out_status_d = status_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    old_q        <= old_d;
    idx_q        <= idx_d;
    slot_q       <= slot_d;
    hit_q        <= hit_d;
    status_q     <= status_d;
    out_found_q  <= out_found_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
    out_full_q   <= out_full_d;
    out_status_q <= out_status_d;
  end

  // The fill count never passes the capacity.
  `SKVT_ASSERT_IMPL(a_count_range, 1'b1, count_q <= CAP_C, "fill count exceeds capacity")
  // A missed key always reports a zero value.
  `SKVT_ASSERT_IMPL(a_miss_zero, m_valid_q && !out_found_q, out_value_q == '0, "miss with value")
  // A table is never reported empty and full at once.
  `SKVT_ASSERT_IMPL(a_flags_excl, m_valid_q, !(out_empty_q && out_full_q), "empty and full together")
  // Entries slide only during a delete that hit.
  `SKVT_ASSERT_IMPL(a_shift_hit, state_q == S_SHIFT_WR, hit_q && (op_q == OP_DELETE), "bad slide")
  // An accepted operation starts the sequencer.
  `SKVT_ASSERT_NEXT(a_busy_after_accept, accept, state_q != S_IDLE, "idle after transfer")

endmodule
